// ===== src/scba_pkg.sv =====
// Package for the size class block allocator.
// Holds the item structs, field widths, operation and status codes.
// No dependencies; used by the allocator top and its testbench.
package scba_pkg;

    localparam int REQ_W   = 10;
    localparam int CLASS_W = 4;
    localparam int SLOT_W  = 3;
    localparam int STAT_W  = 2;

    // Operation codes of an input item.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes of a result item.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM       = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic               op;
        logic [REQ_W-1:0]   request_size;
        logic [CLASS_W-1:0] free_class;
        logic [SLOT_W-1:0]  free_slot;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [CLASS_W-1:0] grant_class;
        logic [SLOT_W-1:0]  grant_slot;
    } t_out_item;

endpackage

// ===== src/scba_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; a read in the cycle after a write sees new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/size_class_block_allocator_top.sv =====
// Size class block allocator: an allocate scans the classes from the first fitting one
// upward and pops the top free entry of the first class with a free block; a request above
// the largest class gives out of memory at once. A free searches the used region of its class
// (at most BLOCKS_PER_CLASS entries) and swaps a hit with the boundary entry; a bad class or
// an empty used region gives not found. One item is in work at a time, the next is taken once
// the result has registered, and an output stall holds the result. Reset runs a clearing pass
// over all NUM_CLASSES*BLOCKS_PER_CLASS stack entries with no item taken. Depends on scba_pkg and scba_ram.
module size_class_block_allocator_top #(
    parameter int NUM_CLASSES      = 10,
    parameter int BLOCKS_PER_CLASS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  scba_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scba_pkg::t_out_item o_out_data
);
    import scba_pkg::*;

    localparam int SD  = NUM_CLASSES * BLOCKS_PER_CLASS;
    localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
    localparam int FAW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FCW = $clog2(BLOCKS_PER_CLASS + 1);
    localparam int IW  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_A_RD  = 13'b0000000000100,
        S_A_CHK = 13'b0000000001000,
        S_A_SLT = 13'b0000000010000,
        S_F_RD  = 13'b0000000100000,
        S_F_CNT = 13'b0000001000000,
        S_S_RD  = 13'b0000010000000,
        S_S_CMP = 13'b0000100000000,
        S_W_RD  = 13'b0001000000000,
        S_W_WR  = 13'b0010000000000,
        S_W_FIN = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [SAW-1:0]      r_clr, n_clr;
    logic [IW-1:0]       r_clr_slot, n_clr_slot;
    logic                r_op, n_op;
    logic [CLASS_W-1:0]  r_cls, n_cls;
    logic [SAW-1:0]      r_base, n_base;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [FCW-1:0]      r_fc, n_fc;
    logic [IW-1:0]       r_idx, n_idx;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [SLOT_W-1:0]   r_gslot, n_gslot;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                st_we;
    logic [SAW-1:0]      st_waddr, st_raddr;
    logic [SLOT_W-1:0]   st_wdata, st_rdata;
    logic                fc_we;
    logic [FAW-1:0]      fc_waddr, fc_raddr;
    logic [FCW-1:0]      fc_wdata, fc_rdata;

    logic [4:0]          first_fit;
    logic                in_acc;

    // Slot stacks of all classes, one row of BLOCKS_PER_CLASS entries per class.
    scba_ram #(.WIDTH(SLOT_W), .DEPTH(SD)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Free count per class.
    scba_ram #(.WIDTH(FCW), .DEPTH(NUM_CLASSES)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (fc_we),
        .i_waddr (fc_waddr),
        .i_wdata (fc_wdata),
        .i_raddr (fc_raddr),
        .o_rdata (fc_rdata)
    );

    // First class whose block size is at least the request; NUM_CLASSES if none.
    always_comb begin
        first_fit = 5'(NUM_CLASSES);
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if ({7'd0, i_in_data.request_size} <= (17'd1 << k)) begin
                first_fit = 5'(k);
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Sequencer: clearing pass, allocate scan and free search with swap.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_clr_slot  = r_clr_slot;
        n_op        = r_op;
        n_cls       = r_cls;
        n_base      = r_base;
        n_slot      = r_slot;
        n_fc        = r_fc;
        n_idx       = r_idx;
        n_status    = r_status;
        n_gslot     = r_gslot;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        st_we       = 1'b0;
        st_waddr    = r_base + SAW'(r_idx);
        st_wdata    = r_slot;
        st_raddr    = r_base + SAW'(r_idx);
        fc_we       = 1'b0;
        fc_waddr    = r_cls[FAW-1:0];
        fc_wdata    = r_fc + FCW'(1);
        fc_raddr    = r_cls[FAW-1:0];

        case (r_state)
            S_INIT: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = SLOT_W'(r_clr_slot);
                fc_we    = ({1'b0, r_clr} < (SAW + 1)'(NUM_CLASSES));
                fc_waddr = r_clr[FAW-1:0];
                fc_wdata = FCW'(BLOCKS_PER_CLASS);
                n_clr    = r_clr + SAW'(1);
                if (r_clr_slot == IW'(BLOCKS_PER_CLASS - 1)) begin
                    n_clr_slot = '0;
                end else begin
                    n_clr_slot = r_clr_slot + IW'(1);
                end
                if (r_clr == SAW'(SD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = i_in_data.op;
                    n_slot  = i_in_data.free_slot;
                    n_gslot = '0;
                    if (i_in_data.op == OP_ALLOC) begin
                        n_cls  = first_fit[CLASS_W-1:0];
                        n_base = SAW'(first_fit[CLASS_W-1:0]) * SAW'(BLOCKS_PER_CLASS);
                        if (first_fit < 5'(NUM_CLASSES)) begin
                            n_state = S_A_RD;
                        end else begin
                            n_status = ST_OOM;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_cls  = i_in_data.free_class;
                        n_base = SAW'(i_in_data.free_class) * SAW'(BLOCKS_PER_CLASS);
                        if ({1'b0, i_in_data.free_class} < 5'(NUM_CLASSES) &&
                            {1'b0, i_in_data.free_class} >= first_fit) begin
                            n_state = S_F_RD;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_A_RD: begin
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                if (fc_rdata == '0) begin
                    // Class empty: move on to the next larger class.
                    if (r_cls == CLASS_W'(NUM_CLASSES - 1)) begin
                        n_status = ST_OOM;
                        n_state  = S_DONE;
                    end else begin
                        n_cls   = r_cls + CLASS_W'(1);
                        n_base  = r_base + SAW'(BLOCKS_PER_CLASS);
                        n_state = S_A_RD;
                    end
                end else begin
                    // Pop: shrink the count and read the top free entry.
                    fc_we    = 1'b1;
                    fc_wdata = fc_rdata - FCW'(1);
                    st_raddr = r_base + SAW'(fc_rdata - FCW'(1));
                    n_state  = S_A_SLT;
                end
            end
            S_A_SLT: begin
                n_gslot  = st_rdata;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_F_RD: begin
                n_state = S_F_CNT;
            end
            S_F_CNT: begin
                n_fc  = fc_rdata;
                n_idx = IW'(BLOCKS_PER_CLASS - 1);
                if (fc_rdata == FCW'(BLOCKS_PER_CLASS)) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_S_RD;
                end
            end
            S_S_RD: begin
                n_state = S_S_CMP;
            end
            S_S_CMP: begin
                // Search the used region from the top down to the free boundary.
                if (st_rdata == r_slot) begin
                    n_state = S_W_RD;
                end else if (FCW'(r_idx) == r_fc) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = S_S_RD;
                end
            end
            S_W_RD: begin
                st_raddr = r_base + SAW'(r_fc);
                n_state  = S_W_WR;
            end
            S_W_WR: begin
                // Boundary entry moves to the hit position.
                st_we    = 1'b1;
                st_wdata = st_rdata;
                n_state  = S_W_FIN;
            end
            S_W_FIN: begin
                // Freed slot lands on the boundary and the count grows.
                st_we    = 1'b1;
                st_waddr = r_base + SAW'(r_fc);
                st_wdata = r_slot;
                fc_we    = 1'b1;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    if (r_op == OP_ALLOC && r_status == ST_OK) begin
                        n_out.grant_class = r_cls;
                        n_out.grant_slot  = r_gslot;
                    end else begin
                        n_out.grant_class = '0;
                        n_out.grant_slot  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_clr_slot  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_slot  <= n_clr_slot;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_cls    <= n_cls;
        r_base   <= n_base;
        r_slot   <= n_slot;
        r_fc     <= n_fc;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_gslot  <= n_gslot;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // An accepted item always leaves the idle state.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // No RAM write while waiting for an item.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!st_we && !fc_we))
        else $error("RAM write while idle");

    // The free search never goes below the free boundary.
    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_S_CMP) |-> (FCW'(r_idx) >= r_fc))
        else $error("free search below boundary");

    // Results other than ok carry no grant.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |->
        (o_out_data.grant_class == '0 && o_out_data.grant_slot == '0))
        else $error("grant fields set on failed item");

endmodule

// ===== sim/size_class_block_allocator_top_tb.sv =====
// Self-checking testbench for size_class_block_allocator_top.
// Drives allocate and free items with bursts and output stalls and checks every result
// against a cycle-free predictor of the pool. Depends on scba_pkg and the allocator RTL.
module size_class_block_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scba_pkg::*;

    localparam int NUM_CLASSES      = 10;
    localparam int BLOCKS_PER_CLASS = 8;
    localparam int COUNT_W          = 4;
    localparam int MAX_REQUEST      = 1 << (NUM_CLASSES - 1);
    localparam int RANDOM_ITEMS     = 700;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_CYCLES     = 64;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PRINT_LIMIT      = 40;

    // Free stack and free count of every class, as the block keeps them.
    typedef struct packed {
        logic [NUM_CLASSES-1:0][BLOCKS_PER_CLASS-1:0][SLOT_W-1:0] stack;
        logic [NUM_CLASSES-1:0][COUNT_W-1:0]                      fcount;
    } t_pool;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // Pool seen by the checker (advanced on accepted items) and by the generator.
    t_pool     pool_now;
    t_pool     pool_gen;

    t_in_item  pending_requests[$];
    t_out_item expected_grants[$];

    logic        in_taken       = 1'b0;
    logic        hold_off       = 1'b0;
    int          gap_left       = 0;
    int          burst_left     = 1;
    int          stall_mode     = 0;
    int          stall_left     = 0;
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_taken    = 0;
    int unsigned results_seen   = 0;
    int unsigned grants_ok      = 0;
    int unsigned grants_oom     = 0;
    int unsigned frees_ok       = 0;
    int unsigned frees_missed   = 0;

    size_class_block_allocator_top #(
        .NUM_CLASSES      (NUM_CLASSES),
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Every entry free, slot i at stack position i.
    function automatic t_pool pool_reset();
        t_pool p;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int i = 0; i < BLOCKS_PER_CLASS; i++)
                p.stack[c][i] = SLOT_W'(i);
            p.fcount[c] = COUNT_W'(BLOCKS_PER_CLASS);
        end
        return p;
    endfunction

    // Smallest class whose block size covers the request; NUM_CLASSES if none does.
    function automatic int first_fit_class(logic [REQ_W-1:0] req);
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if (int'(req) <= (1 << k))
                return k;
        end
        return NUM_CLASSES;
    endfunction

    // Applies one item to a pool and returns the result the block must give.
    function automatic t_out_item predict_grant(inout t_pool p, input t_in_item it);
        t_out_item r;
        int        k;
        int        c;
        int        fc;
        logic      hit;
        logic [SLOT_W-1:0] tmp;
        r   = '0;
        k   = first_fit_class(it.request_size);
        hit = 1'b0;
        if (it.op == OP_ALLOC) begin
            // Walk up from the first fitting class to one with a free block.
            while (k < NUM_CLASSES) begin
                if (p.fcount[k] != 0)
                    break;
                k++;
            end
            if (k >= NUM_CLASSES) begin
                r.status = ST_OOM;
            end else begin
                p.fcount[k]   = p.fcount[k] - 1'b1;
                r.status      = ST_OK;
                r.grant_class = CLASS_W'(k);
                r.grant_slot  = p.stack[k][p.fcount[k]];
            end
        end else begin
            // Only the handle's own class is searched, and only if the search reaches it.
            r.status = ST_NOT_FOUND;
            c = int'(it.free_class);
            if (k <= c && c < NUM_CLASSES) begin
                fc = int'(p.fcount[c]);
                for (int i = BLOCKS_PER_CLASS - 1; i >= fc && !hit; i--) begin
                    if (p.stack[c][i] == it.free_slot) begin
                        tmp            = p.stack[c][i];
                        p.stack[c][i]  = p.stack[c][fc];
                        p.stack[c][fc] = tmp;
                        p.fcount[c]    = COUNT_W'(fc + 1);
                        hit            = 1'b1;
                    end
                end
                if (hit)
                    r.status = ST_OK;
            end
        end
        return r;
    endfunction

    // Queues one item and advances the generator's copy of the pool.
    function automatic void add_item(logic op, int req, int cls, int slot);
        t_in_item it;
        it.op           = op;
        it.request_size = REQ_W'(req);
        it.free_class   = CLASS_W'(cls);
        it.free_slot    = SLOT_W'(slot);
        void'(predict_grant(pool_gen, it));
        pending_requests.insert(pending_requests.size(), it);
    endfunction

    // A request size whose first fitting class is c.
    function automatic int size_for_class(int c);
        if (c == 0)
            return $urandom_range(0, 1);
        return $urandom_range((1 << (c - 1)) + 1, 1 << c);
    endfunction

    // Picks a handle that is currently held, per the generator's pool.
    function automatic logic pick_held(output int cls, output int slot);
        int c0;
        int c;
        c0 = $urandom_range(0, NUM_CLASSES - 1);
        for (int n = 0; n < NUM_CLASSES; n++) begin
            c = (c0 + n) % NUM_CLASSES;
            if (int'(pool_gen.fcount[c]) < BLOCKS_PER_CLASS) begin
                cls  = c;
                slot = int'(pool_gen.stack[c][$urandom_range(int'(pool_gen.fcount[c]),
                                                             BLOCKS_PER_CLASS - 1)]);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Directed items: field extremes, oversize requests, bad and double frees,
    // a class drained to out of memory, and a hit at stack index zero.
    task automatic build_directed();
        add_item(OP_ALLOC, 0, 0, 0);
        add_item(OP_ALLOC, 1, 0, 0);
        add_item(OP_ALLOC, MAX_REQUEST, 0, 0);
        add_item(OP_ALLOC, MAX_REQUEST + 1, 0, 0);
        add_item(OP_ALLOC, (1 << REQ_W) - 1, 0, 0);
        add_item(OP_FREE, 0, 0, 7);
        add_item(OP_FREE, 0, 0, 7);
        add_item(OP_FREE, (1 << REQ_W) - 1, NUM_CLASSES - 1, 7);
        add_item(OP_FREE, 0, (1 << CLASS_W) - 1, 7);
        add_item(OP_FREE, 2, 0, 6);
        add_item(OP_FREE, 1, 0, 6);
        add_item(OP_FREE, 3, NUM_CLASSES - 1, 7);
        for (int n = 0; n < BLOCKS_PER_CLASS + 1; n++)
            add_item(OP_ALLOC, MAX_REQUEST, 0, 0);
        add_item(OP_FREE, MAX_REQUEST, NUM_CLASSES - 1, 0);
        add_item(OP_ALLOC, (MAX_REQUEST / 2) + 1, 0, 0);
        add_item(OP_ALLOC, 300, 0, 0);
        add_item(OP_FREE, 0, NUM_CLASSES - 1, 0);
    endtask

    // Random items in alternating fill and drain phases; most frees name a held handle.
    task automatic build_random();
        int   roll;
        int   cls;
        int   slot;
        logic fill;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            fill = ((n / 60) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                add_item(1'($urandom_range(0, 1)), $urandom_range(0, (1 << REQ_W) - 1),
                         $urandom_range(0, (1 << CLASS_W) - 1),
                         $urandom_range(0, (1 << SLOT_W) - 1));
            end else if (roll < (fill ? 75 : 35) || !pick_held(cls, slot)) begin
                if ($urandom_range(0, 24) == 0)
                    add_item(OP_ALLOC, $urandom_range(MAX_REQUEST + 1, (1 << REQ_W) - 1), 0, 0);
                else
                    add_item(OP_ALLOC, size_for_class($urandom_range(0, NUM_CLASSES - 1)),
                             $urandom_range(0, NUM_CLASSES - 1), $urandom_range(0, 7));
            end else if ($urandom_range(0, 6) != 0) begin
                add_item(OP_FREE, size_for_class($urandom_range(0, cls)), cls, slot);
            end else if (cls < NUM_CLASSES - 1) begin
                // Search starts above the handle's class, so it is never found.
                add_item(OP_FREE, size_for_class($urandom_range(cls + 1, NUM_CLASSES - 1)),
                         cls, slot);
            end else begin
                add_item(OP_FREE, $urandom_range(MAX_REQUEST + 1, (1 << REQ_W) - 1), cls, slot);
            end
        end
    endtask

    // Sender: bursts of items with random gaps; holds an item until it is taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_data  <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, half ready and mostly stalled.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        if (hold_off)
            i_out_ready <= 1'b0;
        else if (stall_mode == 0)
            i_out_ready <= 1'b1;
        else if (stall_mode == 1)
            i_out_ready <= 1'($urandom_range(0, 1));
        else
            i_out_ready <= ($urandom_range(0, 4) == 0);
    end

    // Monitor: checks each result against the oldest prediction, then predicts
    // the result of any item taken at this edge.
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && i_in_valid && (o_in_ready === 1'b1);
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got          = o_out_data;
            results_seen <= results_seen + 1;
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing pending: status %0d",
                                          results_seen, got.status));
            end else begin
                want = expected_grants.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              results_seen, got.status, want.status));
                if (got.grant_class !== want.grant_class)
                    report_mismatch($sformatf("result %0d grant_class %0d, expected %0d",
                                              results_seen, got.grant_class,
                                              want.grant_class));
                if (got.grant_slot !== want.grant_slot)
                    report_mismatch($sformatf("result %0d grant_slot %0d, expected %0d",
                                              results_seen, got.grant_slot, want.grant_slot));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready === 1'b1) begin
            want        = predict_grant(pool_now, i_in_data);
            items_taken <= items_taken + 1;
            expected_grants.insert(expected_grants.size(), want);
            if (i_in_data.op == OP_ALLOC) begin
                if (want.status == ST_OK)
                    grants_ok <= grants_ok + 1;
                else
                    grants_oom <= grants_oom + 1;
            end else begin
                if (want.status == ST_OK)
                    frees_ok <= frees_ok + 1;
                else
                    frees_missed <= frees_missed + 1;
            end
        end
    end

    // Long output stall once traffic is flowing, so the input side backs up.
    initial begin
        wait (results_seen >= 150);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results pending",
                 cycle_count, expected_grants.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, stimulus, and end of run.
    initial begin
        pool_now = pool_reset();
        pool_gen = pool_reset();
        build_directed();
        build_random();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items: %0d grants, %0d out-of-memory, %0d frees,",
                 items_taken, grants_ok, grants_oom, frees_ok);
        $display("%0d frees not found, %0d mismatches, %0d cycles including a %0d-cycle stall.",
                 frees_missed, mismatch_count, cycle_count, HOLD_OFF_CYCLES);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/scba_pkg.sv
src/scba_ram.sv
src/size_class_block_allocator_top.sv
sim/size_class_block_allocator_top_tb.sv
